>>> hdl/rtd_pkg.sv
// Shared types, codes and tables of the ringtone text note decoder.
`default_nettype none
package rtd_pkg;

  // Field widths.
  localparam int CharW  = 8;
  localparam int NumW   = 16;
  localparam int OctW   = 4;
  localparam int HzW    = 20;
  localparam int SoundW = 19;
  localparam int GapW   = 16;
  localparam int WholeW = 18;
  localparam int CfgIdxW = 2;

  // Divider geometry.
  localparam int DivW     = 19;
  localparam int DivSteps = 19;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  // Milliseconds in four beats of one minute.
  localparam logic [DivW-1:0] WholeMinuteMs = DivW'(240000);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_DURATION = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OCTAVE   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TEMPO    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [NumW-1:0] DefDuration = 16'd4;
  localparam logic [OctW-1:0] DefOctave   = 4'd6;
  localparam logic [NumW-1:0] DefTempo    = 16'd63;

  // Event kinds.
  localparam logic [1:0] KIND_TONE  = 2'd0;
  localparam logic [1:0] KIND_REST  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Text parse phases.
  typedef enum logic [3:0] {
    PH_NAME, PH_HSTART, PH_HSPACES, PH_HEQ, PH_HNUM, PH_HPOST, PH_NSTART,
    PH_NDUR, PH_NSHARP, PH_NDOT1, PH_NOCT0, PH_NOCT, PH_NDOT2, PH_NPOST,
    PH_WAIT
  } phase_e;

  // Sequencer states of the controller.
  typedef enum logic [2:0] {
    SQ_IDLE, SQ_STEP, SQ_DIVW, SQ_DIVN, SQ_NOTE, SQ_FLUSH
  } seq_e;

  // Number accumulator operations.
  typedef enum logic [1:0] {
    ACC_HOLD, ACC_CLEAR, ACC_DIGIT, ACC_ACCUM
  } acc_op_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             end_marker;
  } in_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [HzW-1:0]    tone_hz;
    logic [SoundW-1:0] sound_ms;
    logic [GapW-1:0]   gap_ms;
    logic              last_of_run;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    take;
    logic    load_song;
    logic    key_load;
    acc_op_e acc_op;
    logic    apply_pair;
    logic    oct_song;
    logic    oct_load;
    logic    dot_clear;
    logic    dot_set;
    logic    div_load;
    logic    rest_set;
    logic    idx_load;
    logic    idx_inc;
    logic    put_err;
    logic    put_done;
    logic    put_note;
    logic    flush;
    logic    div_start;
    logic    div_note;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_end;
    logic is_colon;
    logic is_space;
    logic is_digit;
    logic is_eq;
    logic is_comma;
    logic is_hash;
    logic is_dot;
    logic is_p;
    logic is_letter;
    logic zero_setting;
    logic pend_valid;
    logic out_free;
    logic div_done;
  } stat_t;

  // Octave-4 frequency of a note index.
  function automatic logic [8:0] base_hz(input logic [3:0] idx);
    logic [8:0] f;
    case (idx)
      4'd0:    f = 9'd262;
      4'd1:    f = 9'd277;
      4'd2:    f = 9'd294;
      4'd3:    f = 9'd311;
      4'd4:    f = 9'd330;
      4'd5:    f = 9'd349;
      4'd6:    f = 9'd370;
      4'd7:    f = 9'd392;
      4'd8:    f = 9'd415;
      4'd9:    f = 9'd440;
      4'd10:   f = 9'd466;
      4'd11:   f = 9'd494;
      default: f = 9'd0;
    endcase
    return f;
  endfunction

  // Tone of a note: doubled per octave above four, halved rounding up below.
  function automatic logic [HzW-1:0] tone_of(input logic [3:0] idx,
                                             input logic [OctW-1:0] oct);
    logic [HzW-1:0] f;
    logic [2:0]     k;
    f = {11'd0, base_hz(idx)};
    k = 3'd0;
    if (oct > 4'd4) begin
      f = f << (oct - 4'd4);
    end else begin
      k = 3'(4'd4 - oct);
      f = (f + ((HzW'(1) << k) - HzW'(1))) >> k;
    end
    return f;
  endfunction

endpackage
`default_nettype wire

>>> hdl/rtd_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rtd_divider (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [rtd_pkg::DivW-1:0]  dividend_i,
  input  wire logic [rtd_pkg::NumW-1:0]  divisor_i,
  output logic                           done_o,
  output logic [rtd_pkg::DivW-1:0]       quotient_o
);

  logic [rtd_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        done_q, done_d;
  logic [rtd_pkg::NumW-1:0]    rem_q, rem_d;
  logic [rtd_pkg::DivW-1:0]    quo_q, quo_d;
  logic [rtd_pkg::NumW-1:0]    dsr_q, dsr_d;
  logic [rtd_pkg::NumW:0]      shifted;
  logic [rtd_pkg::NumW+1:0]    diff;

  // One trial subtraction per step.
  always_comb begin
    shifted = {rem_q, quo_q[rtd_pkg::DivW-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_q};
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      cnt_d = rtd_pkg::DivCntW'(rtd_pkg::DivSteps);
      rem_d = '0;
      quo_d = dividend_i;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - rtd_pkg::DivCntW'(1);
      if (!diff[rtd_pkg::NumW+1]) begin
        rem_d = diff[rtd_pkg::NumW-1:0];
        quo_d = {quo_q[rtd_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted[rtd_pkg::NumW-1:0];
        quo_d = {quo_q[rtd_pkg::DivW-2:0], 1'b0};
      end
      done_d = (cnt_q == rtd_pkg::DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

>>> hdl/rtd_datapath.sv
// Datapath: song settings, note fields, divider and result buffers.
`default_nettype none
module rtd_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rtd_pkg::in_t                in_data_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [rtd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [rtd_pkg::NumW-1:0]    cfg_data_i,
  input  wire logic                        out_ready_i,
  input  wire rtd_pkg::cmd_t               cmd_i,
  output rtd_pkg::stat_t                   stat_o,
  output logic                             out_valid_o,
  output rtd_pkg::out_t                    out_data_o
);

  logic [rtd_pkg::CharW-1:0] char_q;
  logic                      end_q;
  logic [rtd_pkg::NumW-1:0]  def_dur_q, def_tempo_q, song_dur_q, song_tempo_q;
  logic [rtd_pkg::OctW-1:0]  def_oct_q, song_oct_q, note_oct_q;
  logic [rtd_pkg::WholeW-1:0] whole_q, ms_q;
  logic [rtd_pkg::CharW-1:0] key_q;
  logic [rtd_pkg::NumW-1:0]  acc_q, ndiv_q, acc_next;
  logic [3:0]                idx_q;
  logic                      rest_q, dot_q, div_sel_q, div_zero_q;
  rtd_pkg::out_t             pend_q, out_q, new_res;
  logic                      pend_valid_q, out_valid_q;
  logic [19:0]               acc_wide;
  logic [rtd_pkg::CharW-1:0] c_low;
  logic [rtd_pkg::NumW-1:0]  div_divisor;
  logic [rtd_pkg::DivW-1:0]  div_dividend, div_quo;
  logic                      div_done;
  logic [rtd_pkg::SoundW-1:0] note_ms;
  logic [rtd_pkg::SoundW+2:0] ms_x7;
  logic [rtd_pkg::SoundW-1:0] play_ms;
  logic [rtd_pkg::SoundW-1:0] gap_full;
  logic                      out_free, move_out;
  logic [3:0]                letter_idx;

  // Lowercase the incoming byte.
  always_comb begin
    c_low = in_data_i.char_code;
    if (c_low >= "A" && c_low <= "Z") c_low = c_low + 8'd32;
  end

  // Character classes of the held byte and the other status flags.
  always_comb begin
    stat_o.is_end    = end_q;
    stat_o.is_colon  = (char_q == ":");
    stat_o.is_space  = (char_q == " ") || (char_q == 8'h09) ||
                       (char_q == 8'h0d) || (char_q == 8'h0a);
    stat_o.is_digit  = (char_q >= "0") && (char_q <= "9");
    stat_o.is_eq     = (char_q == "=");
    stat_o.is_comma  = (char_q == ",");
    stat_o.is_hash   = (char_q == "#");
    stat_o.is_dot    = (char_q == ".");
    stat_o.is_p      = (char_q == "p");
    stat_o.is_letter = (char_q >= "a") && (char_q <= "g");
    stat_o.zero_setting = (song_tempo_q == '0) || (song_dur_q == '0);
    stat_o.pend_valid = pend_valid_q;
    stat_o.out_free  = out_free;
    stat_o.div_done  = div_done;
  end

  // Semitone index of a note letter.
  always_comb begin
    case (char_q)
      "c":     letter_idx = 4'd0;
      "d":     letter_idx = 4'd2;
      "e":     letter_idx = 4'd4;
      "f":     letter_idx = 4'd5;
      "g":     letter_idx = 4'd7;
      "a":     letter_idx = 4'd9;
      default: letter_idx = 4'd11;
    endcase
  end

  // Decimal accumulator with saturation.
  always_comb begin
    acc_wide = 20'(acc_q) * 20'd10 + 20'(char_q[3:0]);
    case (cmd_i.acc_op)
      rtd_pkg::ACC_CLEAR: acc_next = '0;
      rtd_pkg::ACC_DIGIT: acc_next = rtd_pkg::NumW'(char_q[3:0]);
      rtd_pkg::ACC_ACCUM: acc_next = (acc_wide > 20'd65535) ? 16'hffff : acc_wide[15:0];
      default:            acc_next = acc_q;
    endcase
  end

  // Divider operands.
  always_comb begin
    if (cmd_i.div_note) begin
      div_dividend = rtd_pkg::DivW'(whole_q);
      div_divisor  = (ndiv_q != '0) ? ndiv_q : song_dur_q;
    end else begin
      div_dividend = rtd_pkg::WholeMinuteMs;
      div_divisor  = song_tempo_q;
    end
  end

  rtd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Note timing and the new result.
  always_comb begin
    note_ms  = rtd_pkg::SoundW'(ms_q) + (dot_q ? rtd_pkg::SoundW'(ms_q >> 1) : '0);
    ms_x7    = {3'b000, note_ms} * 22'd7;
    play_ms  = ms_x7[rtd_pkg::SoundW+2:3];
    gap_full = note_ms - play_ms;
    new_res  = '0;
    if (cmd_i.put_err) begin
      new_res.event_kind = rtd_pkg::KIND_ERROR;
    end else if (cmd_i.put_done) begin
      new_res.event_kind = rtd_pkg::KIND_DONE;
    end else if (rest_q) begin
      new_res.event_kind = rtd_pkg::KIND_REST;
      new_res.sound_ms   = note_ms;
    end else begin
      new_res.event_kind = rtd_pkg::KIND_TONE;
      new_res.tone_hz    = rtd_pkg::tone_of(idx_q, note_oct_q);
      new_res.sound_ms   = play_ms;
      new_res.gap_ms     = gap_full[rtd_pkg::GapW-1:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign move_out = cmd_i.flush ||
                    ((cmd_i.put_err || cmd_i.put_done || cmd_i.put_note) && pend_valid_q);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_dur_q    <= rtd_pkg::DefDuration;
      def_oct_q    <= rtd_pkg::DefOctave;
      def_tempo_q  <= rtd_pkg::DefTempo;
      song_dur_q   <= rtd_pkg::DefDuration;
      song_oct_q   <= rtd_pkg::DefOctave;
      song_tempo_q <= rtd_pkg::DefTempo;
      whole_q      <= '0;
      key_q        <= '0;
      acc_q        <= '0;
      idx_q        <= '0;
      note_oct_q   <= '0;
      rest_q       <= 1'b0;
      dot_q        <= 1'b0;
      ndiv_q       <= '0;
      div_sel_q    <= 1'b0;
      div_zero_q   <= 1'b0;
      ms_q         <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          rtd_pkg::CFG_DURATION: def_dur_q   <= cfg_data_i;
          rtd_pkg::CFG_OCTAVE:   def_oct_q   <= cfg_data_i[rtd_pkg::OctW-1:0];
          rtd_pkg::CFG_TEMPO:    def_tempo_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load_song) begin
        song_dur_q   <= def_dur_q;
        song_oct_q   <= def_oct_q;
        song_tempo_q <= def_tempo_q;
      end
      if (cmd_i.apply_pair && acc_q != '0) begin
        if (key_q == "d") song_dur_q <= acc_q;
        else if (key_q == "o") song_oct_q <= (acc_q > 16'd15) ? 4'hf : acc_q[3:0];
        else if (key_q == "b") song_tempo_q <= acc_q;
      end
      if (cmd_i.key_load) key_q <= char_q;
      acc_q <= acc_next;
      if (cmd_i.oct_song) note_oct_q <= song_oct_q;
      if (cmd_i.oct_load) note_oct_q <= (acc_next > 16'd15) ? 4'hf : acc_next[3:0];
      if (cmd_i.dot_clear) dot_q <= 1'b0;
      if (cmd_i.dot_set) dot_q <= 1'b1;
      if (cmd_i.div_load) ndiv_q <= acc_next;
      if (cmd_i.rest_set) begin
        rest_q <= 1'b1;
        idx_q  <= '0;
      end
      if (cmd_i.idx_load) begin
        rest_q <= 1'b0;
        idx_q  <= letter_idx;
      end
      if (cmd_i.idx_inc) idx_q <= idx_q + 4'd1;
      if (cmd_i.div_start) begin
        div_sel_q  <= cmd_i.div_note;
        div_zero_q <= (div_divisor == '0);
      end
      if (div_done) begin
        if (div_sel_q) ms_q <= div_zero_q ? '0 : div_quo[rtd_pkg::WholeW-1:0];
        else whole_q <= div_zero_q ? '0 : div_quo[rtd_pkg::WholeW-1:0];
      end
      // Result buffers: the pending result moves to the output register.
      out_valid_q <= move_out || (out_valid_q && !out_ready_i);
      if (cmd_i.put_err || cmd_i.put_done || cmd_i.put_note) pend_valid_q <= 1'b1;
      else if (cmd_i.flush) pend_valid_q <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      char_q <= c_low;
      end_q  <= in_data_i.end_marker || (in_data_i.char_code == '0);
    end
    if (cmd_i.put_err || cmd_i.put_done || cmd_i.put_note) pend_q <= new_res;
    // The last-of-run flag is the low bit of the result.
    if (move_out) out_q <= {pend_q[$bits(rtd_pkg::out_t)-1:1], cmd_i.flush};
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

>>> hdl/rtd_ctrl.sv
// Controller: parse phase machine and step sequencer.
`default_nettype none
module rtd_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire rtd_pkg::stat_t stat_i,
  output rtd_pkg::cmd_t       cmd_o
);

  rtd_pkg::phase_e phase_q, phase_d;
  rtd_pkg::seq_e   seq_q, seq_d;
  rtd_pkg::cmd_t   act;
  rtd_pkg::phase_e act_phase;
  logic            again, need_put, can_put, ch_e, go_div_w, go_div_n;

  // Register state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rtd_pkg::PH_NAME;
      seq_q   <= rtd_pkg::SQ_IDLE;
    end else begin
      phase_q <= phase_d;
      seq_q   <= seq_d;
    end
  end

  assign can_put = !stat_i.pend_valid || stat_i.out_free;
  assign ch_e    = stat_i.is_end;

  // Action of one parse phase on the held byte.
  always_comb begin
    act       = '0;
    act_phase = phase_q;
    again     = 1'b0;
    go_div_w  = 1'b0;
    go_div_n  = 1'b0;
    unique case (phase_q)
      rtd_pkg::PH_NAME: begin
        if (ch_e) begin
          act.put_err = 1'b1;
        end else if (stat_i.is_colon) begin
          act.load_song = 1'b1;
          act_phase     = rtd_pkg::PH_HSTART;
        end
      end
      rtd_pkg::PH_HSTART: begin
        if (ch_e) begin
          act.put_err = 1'b1;
          act_phase   = rtd_pkg::PH_NAME;
        end else if (stat_i.is_colon) begin
          if (stat_i.zero_setting) begin
            act.put_err = 1'b1;
            act_phase   = rtd_pkg::PH_WAIT;
          end else begin
            act.div_start = 1'b1;
            go_div_w      = 1'b1;
            act_phase     = rtd_pkg::PH_NSTART;
          end
        end else if (stat_i.is_space) begin
          act_phase = rtd_pkg::PH_HSPACES;
        end else begin
          act.key_load = 1'b1;
          act_phase    = rtd_pkg::PH_HEQ;
        end
      end
      rtd_pkg::PH_HSPACES: begin
        if (ch_e) begin
          act.put_err = 1'b1;
          act_phase   = rtd_pkg::PH_NAME;
        end else if (!stat_i.is_space) begin
          act.key_load = 1'b1;
          act_phase    = rtd_pkg::PH_HEQ;
        end
      end
      rtd_pkg::PH_HEQ: begin
        if (!ch_e && stat_i.is_eq) begin
          act.acc_op = rtd_pkg::ACC_CLEAR;
          act_phase  = rtd_pkg::PH_HNUM;
        end else begin
          act.put_err = 1'b1;
          act_phase   = ch_e ? rtd_pkg::PH_NAME : rtd_pkg::PH_WAIT;
        end
      end
      rtd_pkg::PH_HNUM: begin
        if (!ch_e && stat_i.is_digit) begin
          act.acc_op = rtd_pkg::ACC_ACCUM;
        end else begin
          act.apply_pair = 1'b1;
          act_phase      = rtd_pkg::PH_HPOST;
          again          = 1'b1;
        end
      end
      rtd_pkg::PH_HPOST: begin
        if (ch_e || !stat_i.is_space) begin
          act_phase = rtd_pkg::PH_HSTART;
          again     = ch_e || !stat_i.is_comma;
        end
      end
      rtd_pkg::PH_NSTART, rtd_pkg::PH_NDUR: begin
        if (phase_q == rtd_pkg::PH_NSTART && ch_e) begin
          act.put_done = 1'b1;
          act_phase    = rtd_pkg::PH_NAME;
        end else if (phase_q == rtd_pkg::PH_NSTART && stat_i.is_space) begin
          act_phase = phase_q;
        end else if (phase_q == rtd_pkg::PH_NSTART && stat_i.is_digit) begin
          act.oct_song  = 1'b1;
          act.dot_clear = 1'b1;
          act.acc_op    = rtd_pkg::ACC_DIGIT;
          act_phase     = rtd_pkg::PH_NDUR;
        end else if (phase_q == rtd_pkg::PH_NDUR && !ch_e && stat_i.is_digit) begin
          act.acc_op = rtd_pkg::ACC_ACCUM;
        end else begin
          // Start of the note symbol.
          if (phase_q == rtd_pkg::PH_NSTART) begin
            act.oct_song  = 1'b1;
            act.dot_clear = 1'b1;
            act.acc_op    = rtd_pkg::ACC_CLEAR;
          end
          act.div_load = 1'b1;
          if (ch_e) begin
            act.put_err = 1'b1;
            act_phase   = rtd_pkg::PH_NAME;
          end else if (stat_i.is_p) begin
            act.rest_set = 1'b1;
            act_phase    = rtd_pkg::PH_NDOT1;
          end else if (stat_i.is_letter) begin
            act.idx_load = 1'b1;
            act_phase    = rtd_pkg::PH_NSHARP;
          end else begin
            act.put_err = 1'b1;
            act_phase   = rtd_pkg::PH_WAIT;
          end
        end
      end
      rtd_pkg::PH_NSHARP: begin
        act_phase = rtd_pkg::PH_NDOT1;
        if (!ch_e && stat_i.is_hash) act.idx_inc = 1'b1;
        else again = 1'b1;
      end
      rtd_pkg::PH_NDOT1: begin
        act_phase = rtd_pkg::PH_NOCT0;
        if (!ch_e && stat_i.is_dot) act.dot_set = 1'b1;
        else again = 1'b1;
      end
      rtd_pkg::PH_NOCT0, rtd_pkg::PH_NOCT: begin
        if (!ch_e && stat_i.is_digit) begin
          act.acc_op   = (phase_q == rtd_pkg::PH_NOCT0) ? rtd_pkg::ACC_DIGIT
                                                        : rtd_pkg::ACC_ACCUM;
          act.oct_load = 1'b1;
          act_phase    = rtd_pkg::PH_NOCT;
        end else begin
          act_phase = rtd_pkg::PH_NDOT2;
          again     = 1'b1;
        end
      end
      rtd_pkg::PH_NDOT2: begin
        if (!ch_e && stat_i.is_dot) act.dot_set = 1'b1;
        act.div_start = 1'b1;
        act.div_note  = 1'b1;
        go_div_n      = 1'b1;
        act_phase     = rtd_pkg::PH_NPOST;
      end
      rtd_pkg::PH_NPOST: begin
        if (ch_e || !stat_i.is_space) begin
          act_phase = rtd_pkg::PH_NSTART;
          again     = ch_e || !stat_i.is_comma;
        end
      end
      default: begin
        if (ch_e) act_phase = rtd_pkg::PH_NAME;
      end
    endcase
    need_put = act.put_err || act.put_done;
  end

  // Step sequencer.
  always_comb begin
    cmd_o      = '0;
    phase_d    = phase_q;
    seq_d      = seq_q;
    in_ready_o = 1'b0;
    unique case (seq_q)
      rtd_pkg::SQ_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          seq_d      = rtd_pkg::SQ_STEP;
        end
      end
      rtd_pkg::SQ_STEP: begin
        if (!need_put || can_put) begin
          cmd_o   = act;
          phase_d = act_phase;
          if (go_div_w) seq_d = rtd_pkg::SQ_DIVW;
          else if (go_div_n) seq_d = rtd_pkg::SQ_DIVN;
          else if (!again) seq_d = rtd_pkg::SQ_FLUSH;
        end
      end
      rtd_pkg::SQ_DIVW: begin
        if (stat_i.div_done) seq_d = rtd_pkg::SQ_FLUSH;
      end
      rtd_pkg::SQ_DIVN: begin
        if (stat_i.div_done) seq_d = rtd_pkg::SQ_NOTE;
      end
      rtd_pkg::SQ_NOTE: begin
        if (can_put) begin
          cmd_o.put_note = 1'b1;
          seq_d = (!ch_e && stat_i.is_dot) ? rtd_pkg::SQ_FLUSH : rtd_pkg::SQ_STEP;
        end
      end
      rtd_pkg::SQ_FLUSH: begin
        if (!stat_i.pend_valid) begin
          seq_d = rtd_pkg::SQ_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          seq_d       = rtd_pkg::SQ_IDLE;
        end
      end
      default: seq_d = rtd_pkg::SQ_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/ringtone_text_note_decoder_unit.sv
// Top level of the ringtone text note decoder.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_ready_o  in_data_i  (char_code, end_marker)
//   out      output     out_valid_o / out_ready_i out_data_o (event, tone, times, last)
//   cfg      input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// A byte is accepted in the idle state; the sequencer then steps through each
// parse phase that the byte passes and hands its last event to the output
// register. A tempo colon adds a divider wait; the byte that ends a note adds a
// divider wait and a step to post the note event. Reset loads the default
// settings and starts in the name phase. A stalled output holds the pending
// event and the sequencer waits; the next byte is taken once the last event
// sits in the output register.
`default_nettype none
module ringtone_text_note_decoder_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire rtd_pkg::in_t                in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output rtd_pkg::out_t                    out_data_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [rtd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [rtd_pkg::NumW-1:0]    cfg_data_i
);

  rtd_pkg::cmd_t  cmd;
  rtd_pkg::stat_t stat;

  // Controller.
  rtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath.
  rtd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

>>> verif/tb_ringtone_text_note_decoder_unit.sv
// Testbench of the ringtone text note decoder: directed text table plus random songs.
`timescale 1ns / 1ps
module tb_ringtone_text_note_decoder_unit;
  import rtd_pkg::*;

  // One row of the directed text table.
  typedef struct {
    in_t  item;
    bit   typed;
    out_t event_typed;
  } text_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  in_t                in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_t               out_data_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_DURATION;
  logic [NumW-1:0]    cfg_data_i = '0;

  ringtone_text_note_decoder_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Expected events and run bookkeeping.
  out_t        pending_events[$];
  in_t         song_q[$];
  text_row_t   text_table[$];
  int          mismatches = 0;
  int          sender_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;

  // Shadow of the configuration and the parse state.
  int unsigned cfg_dur = 4, cfg_oct = 6, cfg_bpm = 63;
  phase_e      ph = PH_NAME;
  int unsigned song_dur = 4, song_oct = 6, song_bpm = 63, whole_ms = 0;
  int unsigned hkey = 0, acc = 0, nidx = 0, noct = 0, ndiv = 0;
  bit          rest_f = 0, dot_f = 0;
  int          n_put;

  function automatic bit is_blank(int unsigned c);
    return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic bit is_num(int unsigned c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int unsigned sat_accum(int unsigned a, int unsigned c);
    int unsigned v;
    v = a * 10 + (c - "0");
    return v > 65535 ? 65535 : v;
  endfunction

  // Frequency of a note index at an octave; rounds up on each halving.
  function automatic int unsigned pitch_hz(int unsigned idx, int unsigned oct);
    int unsigned table4[12] = '{262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494};
    int unsigned f;
    if (idx >= 12) return 0;
    f = table4[idx];
    if (oct > 4) f = f << (oct - 4);
    while (oct < 4) begin
      f = (f + 1) / 2;
      oct++;
    end
    return f;
  endfunction

  task automatic put_event(logic [1:0] kind, int unsigned hz, int unsigned snd, int unsigned gap);
    out_t ev;
    if (n_put < 2) begin
      ev.event_kind  = kind;
      ev.tone_hz     = hz[HzW-1:0];
      ev.sound_ms    = snd[SoundW-1:0];
      ev.gap_ms      = gap[GapW-1:0];
      ev.last_of_run = 1'b0;
      pending_events.push_back(ev);
      n_put++;
    end
  endtask

  task automatic raise_error(bit at_end);
    put_event(KIND_ERROR, 0, 0, 0);
    ph = at_end ? PH_NAME : PH_WAIT;
  endtask

  task automatic finish_note();
    int unsigned div, ms, play;
    div = ndiv != 0 ? ndiv : song_dur;
    ms = div != 0 ? whole_ms / div : 0;
    if (dot_f) ms += ms / 2;
    play = ms * 7 / 8;
    if (rest_f) put_event(KIND_REST, 0, ms, 0);
    else put_event(KIND_TONE, pitch_hz(nidx, noct), play, ms - play);
  endtask

  task automatic start_note(int unsigned c, bit e);
    ndiv = acc;
    if (e) begin
      raise_error(1'b1);
    end else if (c == "p") begin
      rest_f = 1;
      nidx = 0;
      ph = PH_NDOT1;
    end else begin
      case (c)
        "c": nidx = 0;
        "d": nidx = 2;
        "e": nidx = 4;
        "f": nidx = 5;
        "g": nidx = 7;
        "a": nidx = 9;
        "b": nidx = 11;
        default: nidx = 99;
      endcase
      if (nidx == 99) begin
        raise_error(1'b0);
      end else begin
        rest_f = 0;
        ph = PH_NSHARP;
      end
    end
  endtask

  // Advance the parse state by one accepted request and queue its events.
  task automatic decode_char(in_t it);
    int unsigned c;
    bit e, again;
    c = it.char_code;
    e = it.end_marker || c == 0;
    if (c >= "A" && c <= "Z") c += 32;
    n_put = 0;
    again = 1;
    while (again) begin
      again = 0;
      case (ph)
        PH_NAME: begin
          if (e) raise_error(1'b1);
          else if (c == ":") begin
            song_dur = cfg_dur;
            song_oct = cfg_oct;
            song_bpm = cfg_bpm;
            ph = PH_HSTART;
          end
        end
        PH_HSTART: begin
          if (e) raise_error(1'b1);
          else if (c == ":") begin
            if (song_bpm == 0 || song_dur == 0) raise_error(1'b0);
            else begin
              whole_ms = 240000 / song_bpm;
              ph = PH_NSTART;
            end
          end else if (is_blank(c)) ph = PH_HSPACES;
          else begin
            hkey = c;
            ph = PH_HEQ;
          end
        end
        PH_HSPACES: begin
          if (e) raise_error(1'b1);
          else if (!is_blank(c)) begin
            hkey = c;
            ph = PH_HEQ;
          end
        end
        PH_HEQ: begin
          if (!e && c == "=") begin
            acc = 0;
            ph = PH_HNUM;
          end else raise_error(e);
        end
        PH_HNUM: begin
          if (!e && is_num(c)) acc = sat_accum(acc, c);
          else begin
            // A zero value keeps the current setting.
            if (acc != 0) begin
              if (hkey == "d") song_dur = acc;
              else if (hkey == "o") song_oct = acc > 15 ? 15 : acc;
              else if (hkey == "b") song_bpm = acc;
            end
            ph = PH_HPOST;
            again = 1;
          end
        end
        PH_HPOST: begin
          if (e || !is_blank(c)) begin
            ph = PH_HSTART;
            if (e || c != ",") again = 1;
          end
        end
        PH_NSTART: begin
          if (e) begin
            put_event(KIND_DONE, 0, 0, 0);
            ph = PH_NAME;
          end else if (!is_blank(c)) begin
            noct = song_oct;
            dot_f = 0;
            if (is_num(c)) begin
              acc = c - "0";
              ph = PH_NDUR;
            end else begin
              acc = 0;
              start_note(c, 1'b0);
            end
          end
        end
        PH_NDUR: begin
          if (!e && is_num(c)) acc = sat_accum(acc, c);
          else start_note(c, e);
        end
        PH_NSHARP: begin
          ph = PH_NDOT1;
          if (!e && c == "#") nidx++;
          else again = 1;
        end
        PH_NDOT1: begin
          ph = PH_NOCT0;
          if (!e && c == ".") dot_f = 1;
          else again = 1;
        end
        PH_NOCT0, PH_NOCT: begin
          if (!e && is_num(c)) begin
            acc = ph == PH_NOCT0 ? c - "0" : sat_accum(acc, c);
            noct = acc > 15 ? 15 : acc;
            ph = PH_NOCT;
          end else begin
            ph = PH_NDOT2;
            again = 1;
          end
        end
        PH_NDOT2: begin
          ph = PH_NPOST;
          if (!e && c == ".") dot_f = 1;
          else again = 1;
          finish_note();
        end
        PH_NPOST: begin
          if (e || !is_blank(c)) begin
            ph = PH_NSTART;
            if (e || c != ",") again = 1;
          end
        end
        default: if (e) ph = PH_NAME;
      endcase
    end
    if (n_put > 0) pending_events[pending_events.size()-1].last_of_run = 1'b1;
  endtask

  // Offer one request, with random idle cycles ahead of it.
  task automatic send_char(in_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_char(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[NumW-1:0];
    if (idx == CFG_DURATION) cfg_dur = val & 16'hFFFF;
    else if (idx == CFG_OCTAVE) cfg_oct = val & 4'hF;
    else cfg_bpm = val & 16'hFFFF;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_row(byte unsigned c, bit e, bit typed, logic [1:0] kind);
    text_row_t r;
    r.item.char_code  = c;
    r.item.end_marker = e;
    r.typed = typed;
    r.event_typed = '{event_kind: kind, tone_hz: '0, sound_ms: '0, gap_ms: '0,
                      last_of_run: 1'b1};
    text_table.push_back(r);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 1'b0, KIND_TONE);
  endtask

  // Random text byte, possibly replaced by noise or marked as an end.
  task automatic add_ch(byte unsigned c);
    in_t it;
    it.char_code  = ($urandom_range(99) < 3) ? 8'($urandom_range(255)) : c;
    it.end_marker = ($urandom_range(999) < 3);
    song_q.push_back(it);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) add_ch(s[i]);
  endtask

  // Mixed case letter.
  task automatic add_letter(byte unsigned c);
    add_ch($urandom_range(3) == 0 ? c - 32 : c);
  endtask

  function automatic int unsigned rand_value();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(99999, 65530);
      2: return $urandom_range(65535);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // Build one mostly well-formed song with random content.
  task automatic build_song();
    string keys, notes;
    in_t last;
    int n;
    keys  = "dob";
    notes = "cdefgabp";
    song_q.delete();
    n = $urandom_range(4);
    for (int i = 0; i < n; i++) add_ch(8'($urandom_range("a", "z")));
    add_ch(":");
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(1)) begin
        if ($urandom_range(4) == 0) add_ch(" ");
        add_letter($urandom_range(9) == 0 ? "x" : keys[k]);
        add_ch("=");
        add_str($sformatf("%0d", k == 1 ? $urandom_range(16) : rand_value()));
        if ($urandom_range(5) == 0) add_ch(" ");
        add_ch(",");
      end
    end
    add_ch(":");
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1)) add_str($sformatf("%0d", (1 << $urandom_range(5))));
      else if ($urandom_range(7) == 0) add_str($sformatf("%0d", rand_value()));
      add_letter(notes[$urandom_range(7)]);
      if ($urandom_range(9) < 3) add_ch("#");
      if ($urandom_range(9) < 2) add_ch(".");
      if ($urandom_range(1)) add_str($sformatf("%0d", $urandom_range(9)));
      if ($urandom_range(19) == 0) add_str($sformatf("%0d", $urandom_range(99)));
      if ($urandom_range(9) < 2) add_ch(".");
      if (i != n - 1) begin
        add_ch(",");
        if ($urandom_range(3) == 0) add_ch(8'h09);
      end
    end
    last.char_code  = $urandom_range(4) == 0 ? 8'd0 : 8'($urandom_range(255));
    last.end_marker = last.char_code != 0;
    song_q.push_back(last);
  endtask

  // Receiver readiness: long hold-off first, else random stalls.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each accepted result with the oldest expected event.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected event %p", out_data_o);
      end else begin
        want = pending_events.pop_front();
        if (out_data_o.event_kind !== want.event_kind || out_data_o.tone_hz !== want.tone_hz ||
            out_data_o.sound_ms !== want.sound_ms || out_data_o.gap_ms !== want.gap_ms ||
            out_data_o.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= 10) $display("event mismatch: expected %p, got %p", want, out_data_o);
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int settings[6][3];
    int sent;
    settings = '{'{4, 6, 63}, '{1, 0, 1}, '{65535, 15, 65535}, '{16, 4, 200},
                 '{2, 15, 1}, '{65535, 0, 120}};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed text: early ends, zero byte, saturation, invalid sharp, rest, bad note.
    add_row(8'h00, 1'b1, 1'b1, KIND_ERROR);
    add_row(8'h00, 1'b0, 1'b1, KIND_ERROR);
    add_text(":o=99,b=999999:b#.px");
    add_row(8'hFF, 1'b1, 1'b0, KIND_TONE);
    add_text("::");
    add_row(8'h00, 1'b1, 1'b1, KIND_DONE);
    foreach (text_table[i]) begin
      send_char(text_table[i].item);
      if (text_table[i].typed && n_put > 0)
        pending_events[pending_events.size()-1] = text_table[i].event_typed;
    end
    drain();

    // A zero duration register makes the tempo colon an error.
    write_cfg(CFG_DURATION, 0);
    add_text("");
    send_char('{char_code: ":", end_marker: 1'b0});
    send_char('{char_code: ":", end_marker: 1'b0});
    send_char('{char_code: 8'h00, end_marker: 1'b1});
    drain();

    // Random songs under several settings and idling modes.
    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        write_cfg(CFG_DURATION, settings[p][0]);
        write_cfg(CFG_OCTAVE, settings[p][1]);
        write_cfg(CFG_TEMPO, settings[p][2]);
      end else begin
        write_cfg(CFG_DURATION, 4);
      end
      sender_idle_pct = (p % 4 == 1) ? 50 : (p % 4 == 3) ? 35 : 0;
      stall_pct       = (p % 4 == 2) ? 50 : (p % 4 == 3) ? 35 : 0;
      if (p == 2) hold_left = 400;
      sent = 0;
      while (sent < 100) begin
        build_song();
        foreach (song_q[i]) send_char(song_q[i]);
        sent += song_q.size();
      end
      drain();
    end

    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
